// File: rtl/core/snc_pkg.sv
// Shared types and constants for the sorting network checker.
// Holds the port field widths, the microcode word layout and the sequencer flags.
// No dependencies; every other file imports this package.
package snc_pkg;

   localparam int OP_W     = 1;
   localparam int WIRE_W   = 3;
   localparam int STAGE_W  = 4;
   localparam int LABEL_W  = 8;
   localparam int VALUE_W  = 32;
   localparam int WCFG_W   = 4;
   localparam int SCFG_W   = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam int UPC_W    = 5;

   localparam logic [OP_W-1:0] OP_LABEL  = 1'b0;
   localparam logic [OP_W-1:0] OP_NUMBER = 1'b1;

   localparam logic [LABEL_W-1:0] NO_PAIR_LABEL = 8'h2D;

   localparam logic [CSR_IDX_W-1:0] CSR_WIRES  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STAGES = 2'd1;

   localparam logic [WCFG_W-1:0] WIRES_RESET  = 4'd8;
   localparam logic [SCFG_W-1:0] STAGES_RESET = 5'd16;

   typedef logic [UPC_W-1:0] upc_type;

   typedef enum logic [3:0] {
      CND_NEVER    = 4'd0,
      CND_ALWAYS   = 4'd1,
      CND_NO_START = 4'd2,
      CND_I_MORE   = 4'd3,
      CND_SKIP_J   = 4'd4,
      CND_K_MORE   = 4'd5,
      CND_J_MORE   = 4'd6,
      CND_S_MORE   = 4'd7,
      CND_W_ONE    = 4'd8,
      CND_OUT_BUSY = 4'd9
   } cond_type;

   typedef struct packed {
      cond_type cond;
      upc_type  target;
      logic     req_rdy;
      logic     num_rd;
      logic     copy_wr;
      logic     clr_i;
      logic     inc_i;
      logic     rd_i;
      logic     clr_st;
      logic     inc_st;
      logic     clr_j;
      logic     inc_j;
      logic     j_rd;
      logic     j_load;
      logic     k_rd;
      logic     k_cmp;
      logic     j_wb;
      logic     set_sorted;
      logic     ck_first;
      logic     ck_cmp;
      logic     emit;
   } ucode_type;

   typedef struct packed {
      logic start;
      logic i_more;
      logic skip_j;
      logic k_more;
      logic j_more;
      logic s_more;
      logic w_one;
      logic out_busy;
   } flags_type;

endpackage

// File: rtl/core/sorting_network_checker.sv
// Sorting network checker: label/number stores, working copy and compare datapath.
// Writes are taken one per cycle while idle. A number write marked last starts an
// evaluation, during which no request is taken: a copy of the numbers into the working
// store, a walk of the network stage by stage and a final check of the order (skipped
// for one wire), for w wires and s stages.
// Reset is synchronous and clears the sequencer, the result valid flag and the wire and stage registers.
module sorting_network_checker #(
   parameter int MAX_WIRES  = 8,
   parameter int MAX_STAGES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [snc_pkg::OP_W-1:0]            req_operation,
   input  logic [snc_pkg::WIRE_W-1:0]          req_wire_req,
   input  logic [snc_pkg::STAGE_W-1:0]         req_stage,
   input  logic [snc_pkg::LABEL_W-1:0]         req_label,
   input  logic signed [snc_pkg::VALUE_W-1:0]  req_value,
   input  logic                                req_last,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_is_sorted,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [snc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [snc_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import snc_pkg::*;

   localparam int WB    = $clog2(MAX_WIRES);
   localparam int CB    = $clog2(MAX_WIRES + 1);
   localparam int SB    = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
   localparam int SCB   = $clog2(MAX_STAGES + 1);
   localparam int LDEPTH = MAX_STAGES << WB;

   ucode_type uc;
   flags_type flags;

   logic [WCFG_W-1:0] wires_ff;
   logic [SCFG_W-1:0] stages_ff;
   logic [CB-1:0]     w_eff;
   logic [SCB-1:0]    s_eff;

   logic [LABEL_W-1:0]        label_mem_ff [LDEPTH];
   logic signed [VALUE_W-1:0] num_mem_ff   [MAX_WIRES];
   logic signed [VALUE_W-1:0] work_mem_ff  [MAX_WIRES];

   logic [LABEL_W-1:0]        label_rd_ff;
   logic signed [VALUE_W-1:0] num_rd_ff;
   logic signed [VALUE_W-1:0] work_rd_ff;

   logic [CB-1:0]  i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [SCB-1:0] st_ff, st_in;
   logic [LABEL_W-1:0]        lj_ff, lj_in;
   logic signed [VALUE_W-1:0] acc_ff, acc_in, prev_ff, prev_in;
   logic sorted_ff, sorted_in;
   logic rsp_valid_ff, rsp_valid_in, rsp_is_sorted_ff, rsp_is_sorted_in;

   logic              accept;
   logic              label_we, num_we;
   logic [SB+WB-1:0]  label_wr_addr, label_rd_addr;
   logic              work_we;
   logic              work_re;
   logic [WB-1:0]     work_wr_addr, work_rd_addr;
   logic signed [VALUE_W-1:0] work_wr_data;
   logic              swap;

   snc_useq u_useq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .uc    (uc)
   );

   assign req_ready     = uc.req_rdy;
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_is_sorted = rsp_is_sorted_ff;
   assign accept        = req_valid && req_ready;

   // Out-of-range register values fold into the supported range.
   always_comb begin
      if (wires_ff == '0) begin
         w_eff = CB'(1);
      end else if (wires_ff > MAX_WIRES) begin
         w_eff = CB'(MAX_WIRES);
      end else begin
         w_eff = CB'(wires_ff);
      end
      if (stages_ff == '0) begin
         s_eff = SCB'(1);
      end else if (stages_ff > MAX_STAGES) begin
         s_eff = SCB'(MAX_STAGES);
      end else begin
         s_eff = SCB'(stages_ff);
      end
   end

   assign label_we = accept && (req_operation == OP_LABEL) &&
                     (req_wire_req < MAX_WIRES) && (req_stage < MAX_STAGES);
   assign num_we   = accept && (req_operation == OP_NUMBER) && (req_wire_req < MAX_WIRES);
   assign label_wr_addr = {SB'(req_stage), WB'(req_wire_req)};
   assign label_rd_addr = uc.k_rd ? {st_ff[SB-1:0], k_ff[WB-1:0]}
                                  : {st_ff[SB-1:0], j_ff[WB-1:0]};

   assign swap = (label_rd_ff == lj_ff) && (acc_ff > work_rd_ff);

   always_comb begin
      work_we      = 1'b0;
      work_wr_addr = i_ff[WB-1:0];
      work_wr_data = num_rd_ff;
      if (uc.copy_wr) begin
         work_we = 1'b1;
      end else if (uc.k_cmp) begin
         work_we      = swap;
         work_wr_addr = k_ff[WB-1:0];
         work_wr_data = acc_ff;
      end else if (uc.j_wb) begin
         work_we      = 1'b1;
         work_wr_addr = j_ff[WB-1:0];
         work_wr_data = acc_ff;
      end
      work_re = uc.j_rd || uc.k_rd || uc.rd_i;
      if (uc.j_rd) begin
         work_rd_addr = j_ff[WB-1:0];
      end else if (uc.k_rd) begin
         work_rd_addr = k_ff[WB-1:0];
      end else begin
         work_rd_addr = i_ff[WB-1:0];
      end
   end

   always_comb begin
      flags.start    = req_valid && (req_operation == OP_NUMBER) && req_last;
      flags.i_more   = CB'(i_ff + 1'b1) != w_eff;
      flags.skip_j   = (k_ff == w_eff) || (label_rd_ff == NO_PAIR_LABEL);
      flags.k_more   = CB'(k_ff + 1'b1) != w_eff;
      flags.j_more   = CB'(j_ff + 1'b1) != w_eff;
      flags.s_more   = SCB'(st_ff + 1'b1) != s_eff;
      flags.w_one    = w_eff == CB'(1);
      flags.out_busy = rsp_valid_ff && !rsp_ready;
   end

   always_comb begin
      i_in = i_ff;
      j_in = j_ff;
      k_in = k_ff;
      st_in = st_ff;
      lj_in = lj_ff;
      acc_in = acc_ff;
      prev_in = prev_ff;
      sorted_in = sorted_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_is_sorted_in = rsp_is_sorted_ff;

      if (uc.clr_i) begin
         i_in = '0;
      end else if (uc.inc_i) begin
         i_in = CB'(i_ff + 1'b1);
      end
      if (uc.clr_st) begin
         st_in = '0;
      end else if (uc.inc_st) begin
         st_in = SCB'(st_ff + 1'b1);
      end
      if (uc.clr_j) begin
         j_in = '0;
      end else if (uc.inc_j) begin
         j_in = CB'(j_ff + 1'b1);
      end
      if (uc.j_rd) begin
         k_in = CB'(j_ff + 1'b1);
      end else if (uc.k_cmp) begin
         k_in = CB'(k_ff + 1'b1);
      end
      if (uc.j_load) begin
         lj_in  = label_rd_ff;
         acc_in = work_rd_ff;
      end
      // The smaller value stays on the lower wire, held in the accumulator.
      if (uc.k_cmp && swap) begin
         acc_in = work_rd_ff;
      end
      if (uc.set_sorted) begin
         sorted_in = 1'b1;
      end
      if (uc.ck_first) begin
         prev_in = work_rd_ff;
      end
      if (uc.ck_cmp) begin
         if (prev_ff > work_rd_ff) begin
            sorted_in = 1'b0;
         end
         prev_in = work_rd_ff;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (uc.emit && !flags.out_busy) begin
         rsp_valid_in     = 1'b1;
         rsp_is_sorted_in = sorted_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (label_we) begin
         label_mem_ff[label_wr_addr] <= req_label;
      end
      label_rd_ff <= label_mem_ff[label_rd_addr];
      if (num_we) begin
         num_mem_ff[WB'(req_wire_req)] <= req_value;
      end
      if (uc.num_rd) begin
         num_rd_ff <= num_mem_ff[i_ff[WB-1:0]];
      end
      if (work_we) begin
         work_mem_ff[work_wr_addr] <= work_wr_data;
      end
      if (work_re) begin
         work_rd_ff <= work_mem_ff[work_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in;
      j_ff <= j_in;
      k_ff <= k_in;
      st_ff <= st_in;
      lj_ff <= lj_in;
      acc_ff <= acc_in;
      prev_ff <= prev_in;
      sorted_ff <= sorted_in;
      rsp_is_sorted_ff <= rsp_is_sorted_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         wires_ff     <= WIRES_RESET;
         stages_ff    <= STAGES_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_WIRES:  wires_ff  <= csr_wdata[WCFG_W-1:0];
               CSR_STAGES: stages_ff <= csr_wdata[SCFG_W-1:0];
               default:    ;
            endcase
         end
      end
   end

endmodule

// File: rtl/core/snc_useq.sv
// Microcode sequencer of the sorting network checker: step counter and control ROM.
// Each step emits one control word; a selected datapath flag takes a jump.
// Depends on snc_pkg.
module snc_useq (
   input  logic               clock,
   input  logic               reset,
   input  snc_pkg::flags_type flags,
   output snc_pkg::ucode_type uc
);
   import snc_pkg::*;

   localparam upc_type PC_IDLE    = 5'd0;
   localparam upc_type PC_CP_RD   = 5'd1;
   localparam upc_type PC_CP_WR   = 5'd2;
   localparam upc_type PC_ST_INIT = 5'd3;
   localparam upc_type PC_J_RD    = 5'd4;
   localparam upc_type PC_J_CHK   = 5'd5;
   localparam upc_type PC_K_RD    = 5'd6;
   localparam upc_type PC_K_CMP   = 5'd7;
   localparam upc_type PC_J_WB    = 5'd8;
   localparam upc_type PC_J_NEXT  = 5'd9;
   localparam upc_type PC_S_NEXT  = 5'd10;
   localparam upc_type PC_CK_INIT = 5'd11;
   localparam upc_type PC_CK_RD0  = 5'd12;
   localparam upc_type PC_CK_LD   = 5'd13;
   localparam upc_type PC_CK_RD   = 5'd14;
   localparam upc_type PC_CK_CMP  = 5'd15;
   localparam upc_type PC_DONE    = 5'd16;
   localparam upc_type PC_RET     = 5'd17;

   function automatic ucode_type rom_word(input upc_type pc);
      ucode_type w;
      w = '0;
      w.cond = CND_NEVER;
      w.target = PC_IDLE;
      case (pc)
         PC_IDLE: begin
            w.req_rdy = 1'b1;
            w.clr_i = 1'b1;
            w.cond = CND_NO_START;
            w.target = PC_IDLE;
         end
         PC_CP_RD: begin
            w.num_rd = 1'b1;
         end
         PC_CP_WR: begin
            w.copy_wr = 1'b1;
            w.inc_i = 1'b1;
            w.cond = CND_I_MORE;
            w.target = PC_CP_RD;
         end
         PC_ST_INIT: begin
            w.clr_st = 1'b1;
            w.clr_j = 1'b1;
         end
         PC_J_RD: begin
            w.j_rd = 1'b1;
         end
         PC_J_CHK: begin
            w.j_load = 1'b1;
            w.cond = CND_SKIP_J;
            w.target = PC_J_NEXT;
         end
         PC_K_RD: begin
            w.k_rd = 1'b1;
         end
         PC_K_CMP: begin
            w.k_cmp = 1'b1;
            w.cond = CND_K_MORE;
            w.target = PC_K_RD;
         end
         PC_J_WB: begin
            w.j_wb = 1'b1;
         end
         PC_J_NEXT: begin
            w.inc_j = 1'b1;
            w.cond = CND_J_MORE;
            w.target = PC_J_RD;
         end
         PC_S_NEXT: begin
            w.inc_st = 1'b1;
            w.clr_j = 1'b1;
            w.cond = CND_S_MORE;
            w.target = PC_J_RD;
         end
         PC_CK_INIT: begin
            w.set_sorted = 1'b1;
            w.clr_i = 1'b1;
            w.cond = CND_W_ONE;
            w.target = PC_DONE;
         end
         PC_CK_RD0: begin
            w.rd_i = 1'b1;
            w.inc_i = 1'b1;
         end
         PC_CK_LD: begin
            w.ck_first = 1'b1;
         end
         PC_CK_RD: begin
            w.rd_i = 1'b1;
         end
         PC_CK_CMP: begin
            w.ck_cmp = 1'b1;
            w.inc_i = 1'b1;
            w.cond = CND_I_MORE;
            w.target = PC_CK_RD;
         end
         PC_DONE: begin
            w.emit = 1'b1;
            w.cond = CND_OUT_BUSY;
            w.target = PC_DONE;
         end
         PC_RET: begin
            w.cond = CND_ALWAYS;
            w.target = PC_IDLE;
         end
         default: begin
            w.cond = CND_ALWAYS;
            w.target = PC_IDLE;
         end
      endcase
      return w;
   endfunction

   upc_type pc_ff;
   upc_type pc_in;
   logic    taken;

   assign uc = rom_word(pc_ff);

   always_comb begin
      case (uc.cond)
         CND_NEVER:    taken = 1'b0;
         CND_ALWAYS:   taken = 1'b1;
         CND_NO_START: taken = !flags.start;
         CND_I_MORE:   taken = flags.i_more;
         CND_SKIP_J:   taken = flags.skip_j;
         CND_K_MORE:   taken = flags.k_more;
         CND_J_MORE:   taken = flags.j_more;
         CND_S_MORE:   taken = flags.s_more;
         CND_W_ONE:    taken = flags.w_one;
         CND_OUT_BUSY: taken = flags.out_busy;
         default:      taken = 1'b1;
      endcase
      pc_in = taken ? uc.target : upc_type'(pc_ff + 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// File: rtl/core/snc_checker.sv
// Port-level checks for the sorting network checker, bound to the top level.
// Watches the request and response ports only.
// Depends on snc_pkg and sorting_network_checker.
module snc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic [snc_pkg::OP_W-1:0]            req_operation,
   input logic                                req_last,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic                                rsp_is_sorted
);
   import snc_pkg::*;

   // A result appears only after an evaluation, never straight out of a load cycle.
   a_result_after_eval: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared while requests were being taken");

   // A transfer that starts evaluation stops further requests.
   a_start_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_operation == OP_NUMBER) && req_last) |=> !req_ready)
      else $error("request taken during evaluation");

   // A plain load leaves the block ready for another request in the next cycle.
   a_load_single_cycle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !((req_operation == OP_NUMBER) && req_last)) |=> req_ready)
      else $error("load did not complete in one cycle");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_is_sorted)))
      else $error("stalled result dropped or changed");

endmodule

bind sorting_network_checker snc_checker u_snc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_operation (req_operation),
   .req_last      (req_last),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_is_sorted (rsp_is_sorted)
);
